[rtl/eee_pkg.sv]
`default_nettype none

package eee_pkg;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_B   = 8'h62;
   localparam logic [7:0] CH_LC_E   = 8'h65;
   localparam logic [7:0] CH_LC_F   = 8'h66;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_LC_V   = 8'h76;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_F   = 8'h46;

   localparam logic [7:0] CC_ESC = 8'h1B;
   localparam logic [7:0] CC_LF  = 8'h0A;
   localparam logic [7:0] CC_TAB = 8'h09;
   localparam logic [7:0] CC_CR  = 8'h0D;
   localparam logic [7:0] CC_BEL = 8'h07;
   localparam logic [7:0] CC_BS  = 8'h08;
   localparam logic [7:0] CC_FF  = 8'h0C;
   localparam logic [7:0] CC_VT  = 8'h0B;
   localparam logic [7:0] CC_NUL = 8'h00;

   localparam logic [1:0] HEX_DIGITS = 2'd2;
   localparam logic [1:0] OCT_DIGITS = 2'd3;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [3:0] {
      MODE_PLAIN = 4'b0001,
      MODE_ESC   = 4'b0010,
      MODE_HEX   = 4'b0100,
      MODE_OCT   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd0;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         v = {1'b1, b[3:0]};
      end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
         v = {1'b1, b[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/eee_stream_if.sv]
`default_nettype none

interface eee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface eee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output out_byte, output run_last, output string_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input string_end,
                 output ready);
endinterface

`default_nettype wire

[rtl/eee_decode.sv]
`default_nettype none

module eee_decode
   import eee_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   eee_req_if.sink    req,
   input  wire logic  space,
   output push_type   push
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   mode_type   mode_ff, mode_in;
   logic [7:0] val_ff, val_in;
   logic [1:0] cnt_ff, cnt_in;

   logic       advance;
   logic       take;
   logic       vld0, vld1;
   logic [7:0] byte0, byte1;
   logic       p_vld, p_esc;
   logic [4:0] hexd;
   logic       octv;
   logic [7:0] acc;
   logic [1:0] cnt_nx;

   assign advance   = in_vld_ff && space;
   assign req.ready = !in_vld_ff || space;
   assign take      = req.valid && req.ready;
   assign in_vld_in = take || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_PLAIN;
         val_ff    <= 8'd0;
         cnt_ff    <= 2'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (advance) begin
            mode_ff <= mode_in;
            val_ff  <= val_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.in_last;
      end
   end

   always_comb begin
      p_vld  = (in_byte_ff != CH_BSLASH) || in_last_ff;
      p_esc  = (in_byte_ff == CH_BSLASH) && !in_last_ff;
      hexd   = hex_value(in_byte_ff);
      octv   = (in_byte_ff >= CH_ZERO) && (in_byte_ff <= CH_SEVEN);
      acc    = 8'd0;
      cnt_nx = cnt_ff + 2'd1;
      vld0    = 1'b0;
      vld1    = 1'b0;
      byte0   = in_byte_ff;
      byte1   = in_byte_ff;
      mode_in = mode_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      case (mode_ff)
         MODE_PLAIN: begin
            vld0 = p_vld;
            if (p_esc) begin
               mode_in = MODE_ESC;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            val_in  = 8'd0;
            cnt_in  = 2'd0;
            vld0    = 1'b1;
            case (in_byte_ff)
               CH_LC_E: byte0 = CC_ESC;
               CH_LC_N: byte0 = CC_LF;
               CH_LC_T: byte0 = CC_TAB;
               CH_LC_R: byte0 = CC_CR;
               CH_LC_A: byte0 = CC_BEL;
               CH_LC_B: byte0 = CC_BS;
               CH_LC_F: byte0 = CC_FF;
               CH_LC_V: byte0 = CC_VT;
               CH_X: begin
                  byte0 = CH_X;
                  if (!in_last_ff) begin
                     vld0    = 1'b0;
                     mode_in = MODE_HEX;
                  end
               end
               CH_ZERO: begin
                  byte0 = CC_NUL;
                  if (!in_last_ff) begin
                     vld0    = 1'b0;
                     mode_in = MODE_OCT;
                  end
               end
               default: byte0 = in_byte_ff;
            endcase
         end
         MODE_HEX: begin
            if (hexd[4]) begin
               acc = {val_ff[3:0], hexd[3:0]};
               if (cnt_nx == HEX_DIGITS || in_last_ff) begin
                  vld0    = 1'b1;
                  byte0   = acc;
                  mode_in = MODE_PLAIN;
                  val_in  = 8'd0;
                  cnt_in  = 2'd0;
               end else begin
                  val_in = acc;
                  cnt_in = cnt_nx;
               end
            end else begin
               vld0    = 1'b1;
               byte0   = (cnt_ff != 2'd0) ? val_ff : CH_X;
               vld1    = p_vld;
               mode_in = p_esc ? MODE_ESC : MODE_PLAIN;
               val_in  = 8'd0;
               cnt_in  = 2'd0;
            end
         end
         MODE_OCT: begin
            if (octv) begin
               acc = {val_ff[4:0], in_byte_ff[2:0]};
               if (cnt_nx == OCT_DIGITS || in_last_ff) begin
                  vld0    = 1'b1;
                  byte0   = acc;
                  mode_in = MODE_PLAIN;
                  val_in  = 8'd0;
                  cnt_in  = 2'd0;
               end else begin
                  val_in = acc;
                  cnt_in = cnt_nx;
               end
            end else begin
               vld0    = 1'b1;
               byte0   = val_ff;
               vld1    = p_vld;
               mode_in = p_esc ? MODE_ESC : MODE_PLAIN;
               val_in  = 8'd0;
               cnt_in  = 2'd0;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            val_in  = 8'd0;
            cnt_in  = 2'd0;
         end
      endcase
      if (in_last_ff) begin
         mode_in = MODE_PLAIN;
         val_in  = 8'd0;
         cnt_in  = 2'd0;
      end
   end

   always_comb begin
      push.r0.out_byte   = byte0;
      push.r1.out_byte   = byte1;
      push.r1.run_last   = 1'b1;
      push.r1.string_end = in_last_ff;
      push.r0.run_last   = !vld1;
      push.r0.string_end = !vld1 && in_last_ff;
      if (!advance || !vld0) begin
         push.count = 2'd0;
      end else if (vld1) begin
         push.count = 2'd2;
      end else begin
         push.count = 2'd1;
      end
   end

endmodule

`default_nettype wire

[rtl/eee_rsp_fifo.sv]
`default_nettype none

module eee_rsp_fifo
   import eee_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  push_type   push,
   output logic       space,
   eee_rsp_if.source  rsp
);

   result_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     head_ff, head_in;
   logic [FIFO_AW-1:0]     tail_ff, tail_in;
   logic [FIFO_AW:0]       count_ff, count_in;
   logic                   pop;
   logic [FIFO_AW-1:0]     tail_nx;

   // room for two results, not counting this cycle's pop
   assign space   = count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
   assign pop     = rsp.valid && rsp.ready;
   assign tail_nx = tail_ff + FIFO_AW'(1);

   assign rsp.valid      = count_ff != '0;
   assign rsp.out_byte   = mem_ff[head_ff].out_byte;
   assign rsp.run_last   = mem_ff[head_ff].run_last;
   assign rsp.string_end = mem_ff[head_ff].string_end;

   always_comb begin
      head_in  = pop ? head_ff + FIFO_AW'(1) : head_ff;
      tail_in  = tail_ff + FIFO_AW'(push.count);
      count_in = count_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_nx] <= push.r1;
      end
   end

endmodule

`default_nettype wire

[rtl/echo_escape_expander.sv]
// channel   dir   payload                          transfer
// req       in    in_byte[7:0], in_last            valid && ready
// rsp       out   out_byte[7:0], run_last, string_end   valid && ready
//
// A byte enters an input register, is decoded and its zero, one or two
// results land in a 4-entry result queue; one byte per cycle sustained while
// the queue has room; the queue absorbs a second result's extra transfer.
// req.ready drops while the input register holds a byte and the queue has
// fewer than two free entries. Synchronous reset returns to plain-text mode.
`default_nettype none

module echo_escape_expander
   import eee_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   eee_req_if.sink    req,
   eee_rsp_if.source  rsp
);

   push_type push;
   logic     space;

   eee_decode u_decode (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .space (space),
      .push  (push)
   );

   eee_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .space (space),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
   import eee_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1050;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   eee_req_if req_bus ();
   eee_rsp_if rsp_bus ();

   echo_escape_expander u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #6 clock = ~clock;

   char_item_type char_q[$];
   result_type    expected_q[$];

   int send_idle = 34;
   int recv_idle = 83;
   int chars_taken = 0;
   int results_checked = 0;
   int strings_sent = 0;
   int double_items = 0;
   int errors = 0;
   int idle_cycles = 0;
   int char_total;
   char_item_type pick;

   // decoder state
   mode_type   pmode = MODE_PLAIN;
   logic [7:0] acc_value = 8'd0;
   logic [1:0] acc_digits = 2'd0;
   logic [7:0] got[2];
   int         got_n;

   localparam logic [7:0] ESC_LETTERS[9] = '{CH_LC_E, CH_LC_N, CH_LC_T, CH_LC_R, CH_LC_A,
                                              CH_LC_B, CH_LC_F, CH_LC_V, CH_BSLASH};

   function automatic void put_char(input logic [7:0] b);
      if (got_n < 2) begin
         got[got_n] = b;
         got_n++;
      end
   endfunction

   function automatic void clear_escape();
      pmode = MODE_PLAIN;
      acc_value = 8'd0;
      acc_digits = 2'd0;
   endfunction

   function automatic int hex_of(input logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
      if (b >= CH_LC_A && b <= CH_LC_F) return int'(b - CH_LC_A) + 10;
      if (b >= CH_UC_A && b <= CH_UC_F) return int'(b - CH_UC_A) + 10;
      return -1;
   endfunction

   function automatic void plain_char(input logic [7:0] b, input logic last);
      if (b != CH_BSLASH) put_char(b);
      else if (last) put_char(CH_BSLASH);
      else pmode = MODE_ESC;
   endfunction

   task automatic decode_char(input logic [7:0] b, input logic last);
      int d;
      result_type r;
      got_n = 0;
      case (pmode)
         MODE_ESC: begin
            clear_escape();
            case (b)
               CH_LC_E: put_char(CC_ESC);
               CH_LC_N: put_char(CC_LF);
               CH_LC_T: put_char(CC_TAB);
               CH_LC_R: put_char(CC_CR);
               CH_LC_A: put_char(CC_BEL);
               CH_LC_B: put_char(CC_BS);
               CH_LC_F: put_char(CC_FF);
               CH_LC_V: put_char(CC_VT);
               CH_X: begin
                  if (last) put_char(CH_X);
                  else pmode = MODE_HEX;
               end
               CH_ZERO: begin
                  if (last) put_char(CC_NUL);
                  else pmode = MODE_OCT;
               end
               default: put_char(b);
            endcase
         end
         MODE_HEX: begin
            d = hex_of(b);
            if (d >= 0) begin
               acc_value = {acc_value[3:0], d[3:0]};
               acc_digits++;
               if (acc_digits >= HEX_DIGITS || last) begin
                  put_char(acc_value);
                  clear_escape();
               end
            end else begin
               put_char(acc_digits > 2'd0 ? acc_value : CH_X);
               clear_escape();
               plain_char(b, last);
            end
         end
         MODE_OCT: begin
            if (b >= CH_ZERO && b <= CH_SEVEN) begin
               acc_value = {acc_value[4:0], b[2:0]};
               acc_digits++;
               if (acc_digits >= OCT_DIGITS || last) begin
                  put_char(acc_value);
                  clear_escape();
               end
            end else begin
               put_char(acc_value);
               clear_escape();
               plain_char(b, last);
            end
         end
         default: plain_char(b, last);
      endcase
      if (last) clear_escape();
      if (got_n == 2) double_items++;
      for (int k = 0; k < got_n; k++) begin
         r.out_byte = got[k];
         r.run_last = (k == got_n - 1);
         r.string_end = (k == got_n - 1) && last;
         expected_q.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input int seen, input int want);
      errors++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, seen, want);
   endtask

   task automatic add_char(input logic [7:0] b, input logic last);
      char_item_type c;
      c.b = b;
      c.last = last;
      char_q.push_back(c);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
   endtask

   task automatic add_random_string();
      logic [7:0] buf_q[$];
      int segs;
      int n;
      int v;
      segs = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) begin
         // raw noise
         n = $urandom_range(1, 10);
         repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (segs) begin
            case ($urandom_range(0, 9))
               0, 1, 2: buf_q.push_back(8'($urandom_range(0, 255)));
               3: begin
                  buf_q.push_back(CH_BSLASH);
                  buf_q.push_back(ESC_LETTERS[$urandom_range(0, 8)]);
               end
               4: begin
                  buf_q.push_back(CH_BSLASH);
                  buf_q.push_back(8'($urandom_range(0, 255)));
               end
               5, 6: begin
                  buf_q.push_back(CH_BSLASH);
                  buf_q.push_back(CH_X);
                  n = $urandom_range(0, 3);
                  repeat (n) begin
                     v = $urandom_range(0, 15);
                     if (v < 10) buf_q.push_back(8'(CH_ZERO + v));
                     else if ($urandom_range(0, 1)) buf_q.push_back(8'(CH_LC_A + v - 10));
                     else buf_q.push_back(8'(CH_UC_A + v - 10));
                  end
               end
               7, 8: begin
                  buf_q.push_back(CH_BSLASH);
                  buf_q.push_back(CH_ZERO);
                  n = $urandom_range(0, 4);
                  repeat (n) buf_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
               end
               default: buf_q.push_back(CH_BSLASH);
            endcase
         end
      end
      foreach (buf_q[i]) add_char(buf_q[i], i == buf_q.size() - 1);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.in_byte <= 8'd0;
         req_bus.in_last <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            pick = char_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.in_byte <= pick.b;
            req_bus.in_last <= pick.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            decode_char(req_bus.in_byte, req_bus.in_last);
            chars_taken++;
            if (req_bus.in_last) strings_sent++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transfer, out_byte", int'(rsp_bus.out_byte), 0);
            end else begin
               result_type want;
               want = expected_q.pop_front();
               if (rsp_bus.out_byte !== want.out_byte)
                  report_mismatch("out_byte", int'(rsp_bus.out_byte), int'(want.out_byte));
               if (rsp_bus.run_last !== want.run_last)
                  report_mismatch("run_last", int'(rsp_bus.run_last), int'(want.run_last));
               if (rsp_bus.string_end !== want.string_end)
                  report_mismatch("string_end", int'(rsp_bus.string_end),
                                  int'(want.string_end));
               results_checked++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'd0;
      req_bus.in_last = 1'b0;
      rsp_bus.ready = 1'b0;

      // all control escapes, escaped backslash, bare \x at end
      add_text("\\e\\n\\t\\r\\a\\b\\f\\v\\\\\\x");
      // octal overflow
      add_text("\\0777");
      add_char(8'hFF, 1'b0);
      add_char(8'h00, 1'b1);
      // trailing backslash
      add_text("\\");
      while (char_q.size() < ITEM_TARGET) add_random_string();
      char_total = char_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (chars_taken < char_total / 3) @(posedge clock);
      send_idle <= 83;
      recv_idle <= 34;
      while (chars_taken < 2 * char_total / 3) @(posedge clock);
      send_idle <= 0;
      recv_idle <= 0;
      while (chars_taken < char_total) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_q.size() > 0)
         report_mismatch("results never delivered", expected_q.size(), 0);
      $display("%0d characters in %0d strings decoded, %0d results checked.",
               chars_taken, strings_sent, results_checked);
      $display("%0d characters produced two results; %0d mismatches.", double_items, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
